@@ hdl/ghst_pkg.sv @@
// Shared types, constants and helpers for the generational handle slot table.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package ghst_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int GEN_W      = 32;
  localparam int TAG_W      = 32;
  localparam int OP_W       = 2;
  localparam int STAT_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_INVAL  = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_NULL  = 2'd1,
    ST_FULL  = 2'd2,
    ST_STALE = 2'd3
  } status_e;

  // Input transaction, last field in the lowest bits.
  typedef struct packed {
    logic [TAG_W-1:0] payload_tag;
    logic [GEN_W-1:0] handle_generation;
    logic [IDX_W-1:0] slot_index;
    op_e              opcode;
  } item_t;

  // Result transaction, last field in the lowest bits.
  typedef struct packed {
    logic [TAG_W-1:0] out_payload;
    logic [GEN_W-1:0] out_generation;
    logic [IDX_W-1:0] out_index;
    status_e          status;
  } result_t;

  localparam int ITEM_W   = $bits(item_t);
  localparam int RESULT_W = $bits(result_t);

  typedef struct packed {
    logic [GEN_W-1:0] gen;
    logic [TAG_W-1:0] tag;
  } slot_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_POP,
    S_CHECK,
    S_WALK_RD,
    S_WALK_WR
  } ctrl_state_e;

  typedef enum logic [1:0] {
    ADDR_ITEM = 2'd0,
    ADDR_POP  = 2'd1,
    ADDR_WALK = 2'd2
  } addr_sel_e;

  typedef enum logic [2:0] {
    WR_NONE        = 3'd0,
    WR_TAG         = 3'd1,
    WR_FRESH       = 3'd2,
    WR_RETIRE_ITEM = 3'd3,
    WR_RETIRE_WALK = 3'd4
  } wr_kind_e;

  typedef enum logic [1:0] {
    RES_NONE    = 2'd0,
    RES_HANDLE  = 2'd1,
    RES_FRESH   = 2'd2,
    RES_PAYLOAD = 2'd3
  } res_kind_e;

  typedef struct packed {
    logic      load_item;
    logic      pop;
    logic      slot_rd;
    addr_sel_e rd_sel;
    wr_kind_e  slot_wr;
    logic      walk_adv;
    logic      free_from_used;
    logic      res_load;
    status_e   res_status;
    res_kind_e res_kind;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic tag_null;
    logic gen_null;
    logic idx_bad;
    logic stack_empty;
    logic stack_full;
    logic table_full;
    logic gen_match;
    logic tag_match;
    logic walk_last;
    logic walk_none;
    logic out_free;
  } dp_stat_t;

  // Next generation, wrapping modulo 2^GEN_W and skipping zero.
  function automatic logic [GEN_W-1:0] advance_gen(input logic [GEN_W-1:0] g);
    logic [GEN_W-1:0] n;
    n = g + GEN_W'(1);
    return (n == '0) ? GEN_W'(1) : n;
  endfunction

endpackage

`default_nettype wire

@@ hdl/ghst_datapath.sv @@
// Datapath of the handle table: slot and free-stack memories, counters,
// compares and the result register. Driven by ghst_ctrl; uses ghst_pkg.
`default_nettype none

module ghst_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [ghst_pkg::ITEM_W-1:0]    item_i,
  input  ghst_pkg::dp_cmd_t              cmd_i,
  output ghst_pkg::dp_stat_t             stat_o,
  input  logic                           m_ready_i,
  output logic                           m_valid_o,
  output logic [ghst_pkg::RESULT_W-1:0]  m_data_o
);
  import ghst_pkg::*;

  item_t            item_q;
  slot_t            slot_mem [SLOT_COUNT];
  slot_t            slot_rd_q;
  logic [IDX_W-1:0] stack_mem [SLOT_COUNT];
  logic [IDX_W-1:0] pop_idx_q;

  logic [CNT_W-1:0] used_q, used_d;
  logic [CNT_W-1:0] free_count_q, free_count_d;
  logic [IDX_W-1:0] walk_q, walk_d;
  logic             m_valid_q, m_valid_d;
  result_t          m_data_q, res_d;

  logic [IDX_W-1:0] rd_addr, wr_addr, pop_addr;
  logic             wr_en;
  slot_t            wr_data;
  logic             out_free;

  // Capture the accepted transaction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= item_t'(item_i);
    end
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      ADDR_ITEM: rd_addr = item_q.slot_index;
      ADDR_POP:  rd_addr = pop_idx_q;
      ADDR_WALK: rd_addr = walk_q;
      default:   rd_addr = item_q.slot_index;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = item_q.slot_index;
    wr_data = '0;
    unique case (cmd_i.slot_wr)
      WR_NONE: begin
        wr_en = 1'b0;
      end
      WR_TAG: begin
        wr_addr = pop_idx_q;
        wr_data = '{gen: slot_rd_q.gen, tag: item_q.payload_tag};
      end
      WR_FRESH: begin
        wr_addr = used_q[IDX_W-1:0];
        wr_data = '{gen: GEN_W'(1), tag: item_q.payload_tag};
      end
      WR_RETIRE_ITEM: begin
        wr_addr = item_q.slot_index;
        wr_data = '{gen: advance_gen(slot_rd_q.gen), tag: '0};
      end
      WR_RETIRE_WALK: begin
        wr_addr = walk_q;
        wr_data = '{gen: advance_gen(slot_rd_q.gen), tag: '0};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.slot_rd) begin
      slot_rd_q <= slot_mem[rd_addr];
    end
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
  end

  // Free stack: pop reads the top entry, retire writes push an index.
  assign pop_addr = IDX_W'(free_count_q - CNT_W'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      pop_idx_q <= stack_mem[pop_addr];
    end
    if (cmd_i.slot_wr == WR_RETIRE_ITEM) begin
      stack_mem[free_count_q[IDX_W-1:0]] <= item_q.slot_index;
    end else if (cmd_i.slot_wr == WR_RETIRE_WALK) begin
      stack_mem[walk_q] <= walk_q;
    end
  end

  always_comb begin
    free_count_d = free_count_q;
    if (cmd_i.free_from_used) begin
      free_count_d = used_q;
    end else if (cmd_i.pop) begin
      free_count_d = free_count_q - CNT_W'(1);
    end else if (cmd_i.slot_wr == WR_RETIRE_ITEM) begin
      free_count_d = free_count_q + CNT_W'(1);
    end
  end

  assign used_d = (cmd_i.slot_wr == WR_FRESH) ? used_q + CNT_W'(1) : used_q;

  always_comb begin
    walk_d = walk_q;
    if (cmd_i.load_item) begin
      walk_d = '0;
    end else if (cmd_i.walk_adv) begin
      walk_d = walk_q + IDX_W'(1);
    end
  end

  // Result register: hold until the receiver takes it.
  assign out_free = !m_valid_q || m_ready_i;

  always_comb begin
    res_d        = '0;
    res_d.status = cmd_i.res_status;
    unique case (cmd_i.res_kind)
      RES_NONE: begin
      end
      RES_HANDLE: begin
        res_d.out_index      = pop_idx_q;
        res_d.out_generation = slot_rd_q.gen;
      end
      RES_FRESH: begin
        res_d.out_index      = used_q[IDX_W-1:0];
        res_d.out_generation = GEN_W'(1);
      end
      RES_PAYLOAD: begin
        res_d.out_payload = slot_rd_q.tag;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_i.res_load) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      m_data_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q       <= '0;
      free_count_q <= '0;
      walk_q       <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      used_q       <= used_d;
      free_count_q <= free_count_d;
      walk_q       <= walk_d;
      m_valid_q    <= m_valid_d;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;

  always_comb begin
    stat_o             = '0;
    stat_o.op          = item_q.opcode;
    stat_o.tag_null    = (item_q.payload_tag == '0);
    stat_o.gen_null    = (item_q.handle_generation == '0);
    stat_o.idx_bad     = ({1'b0, item_q.slot_index} >= used_q);
    stat_o.stack_empty = (free_count_q == '0);
    stat_o.stack_full  = (free_count_q == CNT_W'(SLOT_COUNT));
    stat_o.table_full  = (used_q == CNT_W'(SLOT_COUNT));
    stat_o.gen_match   = (slot_rd_q.gen == item_q.handle_generation);
    stat_o.tag_match   = (slot_rd_q.tag == item_q.payload_tag);
    stat_o.walk_last   = ({1'b0, walk_q} == used_q - CNT_W'(1));
    stat_o.walk_none   = (used_q == '0);
    stat_o.out_free    = out_free;
  end

`ifndef NO_ASSERTIONS
  a_free_le_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_count_q <= used_q)
    else $error("free count exceeds used slots");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(SLOT_COUNT))
    else $error("used slots exceed table size");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> free_count_q != '0)
    else $error("pop from empty free stack");

  a_res_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |-> out_free)
    else $error("result overwrites a pending transaction");
`endif

endmodule

`default_nettype wire

@@ hdl/ghst_ctrl.sv @@
// Controller state machine of the handle table: sequences reads, write-backs
// and the invalidate walk. Drives s_ready_o and the datapath; uses ghst_pkg.
`default_nettype none

module ghst_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  ghst_pkg::dp_stat_t stat_i,
  output ghst_pkg::dp_cmd_t  cmd_o
);
  import ghst_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        unique case (stat_i.op)
          OP_ALLOC: begin
            if (!stat_i.tag_null && !stat_i.stack_empty) begin
              state_d = S_POP;
            end else if (stat_i.out_free) begin
              state_d = S_IDLE;
            end
          end
          OP_FREE: begin
            if (!(stat_i.gen_null || stat_i.tag_null || stat_i.idx_bad ||
                  stat_i.stack_full)) begin
              state_d = S_CHECK;
            end else if (stat_i.out_free) begin
              state_d = S_IDLE;
            end
          end
          OP_LOOKUP: begin
            if (!(stat_i.gen_null || stat_i.idx_bad)) begin
              state_d = S_CHECK;
            end else if (stat_i.out_free) begin
              state_d = S_IDLE;
            end
          end
          OP_INVAL: begin
            if (!stat_i.walk_none) begin
              state_d = S_WALK_WR;
            end else if (stat_i.out_free) begin
              state_d = S_IDLE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_POP: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      S_WALK_RD: begin
        state_d = S_WALK_WR;
      end
      S_WALK_WR: begin
        if (!stat_i.walk_last) begin
          state_d = S_WALK_RD;
        end else if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o       = 1'b1;
        cmd_o.load_item = s_valid_i;
      end
      S_DECIDE: begin
        unique case (stat_i.op)
          OP_ALLOC: begin
            if (stat_i.tag_null) begin
              cmd_o.res_load   = stat_i.out_free;
              cmd_o.res_status = ST_NULL;
            end else if (!stat_i.stack_empty) begin
              cmd_o.pop = 1'b1;
            end else if (!stat_i.table_full) begin
              cmd_o.res_load   = stat_i.out_free;
              cmd_o.res_status = ST_OK;
              cmd_o.res_kind   = RES_FRESH;
              cmd_o.slot_wr    = stat_i.out_free ? WR_FRESH : WR_NONE;
            end else begin
              cmd_o.res_load   = stat_i.out_free;
              cmd_o.res_status = ST_FULL;
            end
          end
          OP_FREE: begin
            if (stat_i.gen_null || stat_i.tag_null || stat_i.idx_bad ||
                stat_i.stack_full) begin
              cmd_o.res_load   = stat_i.out_free;
              cmd_o.res_status = ST_NULL;
            end else begin
              cmd_o.slot_rd = 1'b1;
              cmd_o.rd_sel  = ADDR_ITEM;
            end
          end
          OP_LOOKUP: begin
            if (stat_i.gen_null || stat_i.idx_bad) begin
              cmd_o.res_load   = stat_i.out_free;
              cmd_o.res_status = ST_NULL;
            end else begin
              cmd_o.slot_rd = 1'b1;
              cmd_o.rd_sel  = ADDR_ITEM;
            end
          end
          OP_INVAL: begin
            if (stat_i.walk_none) begin
              cmd_o.res_load       = stat_i.out_free;
              cmd_o.free_from_used = stat_i.out_free;
              cmd_o.res_status     = ST_OK;
            end else begin
              cmd_o.slot_rd = 1'b1;
              cmd_o.rd_sel  = ADDR_WALK;
            end
          end
          default: begin
          end
        endcase
      end
      S_POP: begin
        cmd_o.slot_rd = 1'b1;
        cmd_o.rd_sel  = ADDR_POP;
      end
      S_CHECK: begin
        if (stat_i.out_free) begin
          cmd_o.res_load = 1'b1;
          unique case (stat_i.op)
            OP_ALLOC: begin
              cmd_o.slot_wr    = WR_TAG;
              cmd_o.res_status = ST_OK;
              cmd_o.res_kind   = RES_HANDLE;
            end
            OP_FREE: begin
              if (stat_i.gen_match && stat_i.tag_match) begin
                cmd_o.slot_wr    = WR_RETIRE_ITEM;
                cmd_o.res_status = ST_OK;
              end else begin
                cmd_o.res_status = ST_STALE;
              end
            end
            OP_LOOKUP: begin
              if (stat_i.gen_match) begin
                cmd_o.res_status = ST_OK;
                cmd_o.res_kind   = RES_PAYLOAD;
              end else begin
                cmd_o.res_status = ST_STALE;
              end
            end
            default: begin
              cmd_o.res_status = ST_OK;
            end
          endcase
        end
      end
      S_WALK_RD: begin
        cmd_o.slot_rd = 1'b1;
        cmd_o.rd_sel  = ADDR_WALK;
      end
      S_WALK_WR: begin
        if (!stat_i.walk_last) begin
          cmd_o.slot_wr  = WR_RETIRE_WALK;
          cmd_o.walk_adv = 1'b1;
        end else if (stat_i.out_free) begin
          cmd_o.slot_wr        = WR_RETIRE_WALK;
          cmd_o.free_from_used = 1'b1;
          cmd_o.res_load       = 1'b1;
          cmd_o.res_status     = ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/generational_handle_slot_table.sv @@
// Top level of the generational handle slot table: stream ports, controller
// and datapath. Depends on ghst_pkg, ghst_ctrl and ghst_datapath.
//
// Usage:
//  - One request transaction enters on the s_axis group and yields exactly one
//    result transaction on the m_axis group, in order.
//  - Requests: allocate (payload tag), free (index, generation, tag), lookup
//    (index, generation) and invalidate-all.
//  - Steps per request, from the accepting cycle through the result load;
//    the next request can be accepted in the cycle after the result load:
//      rejected request or allocate of a never-used slot: decision and result
//      free, lookup: slot read, then compare and write-back
//      allocate from the free stack: stack pop, slot read, write-back
//      invalidate-all: read and write-back per used slot
//    One request is worked on at a time.
//  - s_axis_tready is high only while the controller is idle; a new request
//    can be accepted while the previous result still waits in the output
//    register.
//  - When the receiver stalls, the result is held and the controller stops
//    before its final write-back until the output register is free.
//  - Reset empties the table: no slot used, free stack empty, no result.
//    Slot contents are written before first use, so no clearing pass runs.
`default_nettype none

module generational_handle_slot_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // opcode[1:0], slot_index[7:2], handle_generation[39:8], payload_tag[71:40]
  input  logic [ghst_pkg::ITEM_W-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status[1:0], out_index[7:2], out_generation[39:8], out_payload[71:40]
  output logic [ghst_pkg::RESULT_W-1:0] m_axis_tdata
);
  import ghst_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ghst_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  ghst_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (s_axis_tdata),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire
